FILE: src/msk_pkg.sv
// Shared types and constants for the min-tracking stack.
`timescale 1ns / 1ps

package msk_pkg;

  localparam int WORD_WIDTH = 32;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t  command;
    word_t push_value;
  } in_item_t;

  typedef struct packed {
    word_t   popped_value;
    word_t   current_minimum;
    logic    is_empty;
    status_t status;
  } out_item_t;

endpackage

FILE: src/msk_mem.sv
// Synchronous word memory: one write port, one read port with registered data.
`timescale 1ns / 1ps

module msk_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  msk_pkg::word_t           wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output msk_pkg::word_t           rdata
);
  import msk_pkg::*;

  word_t mem [DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read strobe
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/min_tracking_stack.sv
// Top level of the min-tracking stack: control, counters and result register.
`timescale 1ns / 1ps

// LIFO stack of signed words that reports its current minimum with every result.
// Each transaction has two steps: in the accept cycle the block reads the
// top value and the next-lower minimum from the two stack memories, and in the
// execute state, once the output register is free, it writes (push) or uses
// the read data (pop), updates the counters and loads the result register.
// A new transaction is accepted only after that execute step, so the block
// takes one item at a time, as the memories register their read data. A
// result left waiting in the output register does not block acceptance; it
// stalls only the execute step of the following item. A push while full is
// dropped with overflow status, a pop while empty returns zero with underflow
// status. An empty stack reports the largest signed word as its minimum. No
// clearing pass is needed after reset.
module min_tracking_stack #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  msk_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output msk_pkg::out_item_t  out_data
);
  import msk_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   ec_r, ec_nxt;
  logic [CW-1:0]   mc_r, mc_nxt;
  word_t           min_r, min_nxt;
  cmd_t            cmd_r;
  word_t           val_r;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  logic            accept;
  logic            exec_go;
  logic [CW-1:0]   ec_m1, mc_m2;
  logic            v_we, m_we;
  word_t           v_rdata, m_rdata;
  out_item_t       result;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign exec_go  = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign ec_m1    = ec_r - CW'(1);
  assign mc_m2    = mc_r - CW'(2);

  msk_mem #(.DEPTH(DEPTH)) u_value_mem (
    .clk   (clk),
    .we    (v_we),
    .waddr (ec_r[AW-1:0]),
    .wdata (val_r),
    .re    (accept),
    .raddr (ec_m1[AW-1:0]),
    .rdata (v_rdata)
  );

  // minima stack: the top sits in min_r, the memory read fetches the one below
  msk_mem #(.DEPTH(DEPTH)) u_minima_mem (
    .clk   (clk),
    .we    (m_we),
    .waddr (mc_r[AW-1:0]),
    .wdata (val_r),
    .re    (accept),
    .raddr (mc_m2[AW-1:0]),
    .rdata (m_rdata)
  );

  always_comb begin
    ec_nxt = ec_r;
    mc_nxt = mc_r;
    min_nxt = min_r;
    v_we = 1'b0;
    m_we = 1'b0;
    result.popped_value = '0;
    result.status = ST_OK;
    if (exec_go) begin
      unique case (cmd_r)
        CMD_PUSH: begin
          if (ec_r == FULL_COUNT) begin
            result.status = ST_OVERFLOW;
          end else begin
            v_we = 1'b1;
            ec_nxt = ec_r + CW'(1);
            if (val_r <= min_r) begin
              m_we = 1'b1;
              mc_nxt = mc_r + CW'(1);
              min_nxt = val_r;
            end
          end
        end
        CMD_POP: begin
          if (ec_r == '0) begin
            result.status = ST_UNDERFLOW;
          end else begin
            ec_nxt = ec_m1;
            result.popped_value = v_rdata;
            if (mc_r != '0 && v_rdata == min_r) begin
              mc_nxt = mc_r - CW'(1);
              min_nxt = (mc_r > CW'(1)) ? m_rdata : WORD_MAX;
            end
          end
        end
        default: ;
      endcase
    end
    result.current_minimum = min_nxt;
    result.is_empty = (ec_nxt == '0);
  end

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (exec_go) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = result;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ec_r <= '0;
      mc_r <= '0;
      min_r <= WORD_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ec_r <= ec_nxt;
      mc_r <= mc_nxt;
      min_r <= min_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      cmd_r <= in_data.command;
      val_r <= in_data.push_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ec_r <= FULL_COUNT)
    else $error("entry count above depth");

  a_minima_le_entries: assert property (@(posedge clk) disable iff (!rst_n)
    mc_r <= ec_r)
    else $error("minima count above entry count");

  a_empty_minimum: assert property (@(posedge clk) disable iff (!rst_n)
    mc_r == '0 |-> min_r == WORD_MAX)
    else $error("minimum not reset with empty minima stack");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready && (ec_r == $past(ec_r)))
    else $error("second transaction or early count change after accept");

endmodule
